### hdl/csrmv_pkg.sv
package csrmv_pkg;

  localparam int IDX_W       = 12;
  localparam int DIM_W       = 13;
  localparam int VAL_W       = 32;
  localparam int ACC_W       = 64;
  localparam int FRAC_W      = 16;
  localparam int VEC_DEPTH   = 4096;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_NONZERO = 2'd1;
  localparam logic [1:0] OP_ROW_END = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = 13'd4096;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             in_range;
  } item_t;

endpackage

### hdl/sparse_csr_matvec_unit.sv
// Sparse matrix-vector product y = A*x, with A streamed row by row in
// compressed-row order and all values in signed Q16.16.
// The input channel (in_valid/in_ready) takes one transaction per cycle:
// a load writes one x element, a nonzero multiplies its value by the stored
// x entry of its column and adds the product to the 64-bit row sum, and an
// end-of-row transaction sends the row's floored, saturated sum out.
// The output channel (out_valid/out_ready) carries row_result, row_number
// and last_row; only end-of-row transactions produce one.
// A result passes the front register, the queue, stage 1, stage 2 and the
// output register. Throughput is one transaction per cycle while the output
// is not stalled, set by the single port of the 4096-entry x store and the
// one multiplier, each used once per transaction.
// When the receiver stalls, the back pipeline holds and the four-entry
// queue behind the front stage fills; in_ready then drops.
// Reset clears the row sum, the row counter and the pipeline, and sets
// num_rows to 4096. The x store is not cleared: load an element before a
// nonzero reads it. num_rows sits at APB address 0; it must be written
// only while the block is idle, which the block itself does not enforce.
module sparse_csr_matvec_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  operation,
  input  logic [csrmv_pkg::IDX_W-1:0] vector_index,
  input  logic [csrmv_pkg::VAL_W-1:0] vector_value,
  input  logic [csrmv_pkg::VAL_W-1:0] matrix_value,
  input  logic [csrmv_pkg::IDX_W-1:0] column,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [csrmv_pkg::VAL_W-1:0] row_result,
  output logic [csrmv_pkg::IDX_W-1:0] row_number,
  output logic                        last_row
);

  logic [csrmv_pkg::DIM_W-1:0] num_rows;
  logic [csrmv_pkg::DIM_W-1:0] dim;
  logic                        reg_sel;

  logic                        front_valid;
  logic                        front_ready;
  csrmv_pkg::item_t            front_item;
  logic                        queue_valid;
  logic                        queue_ready;
  csrmv_pkg::item_t            queue_item;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {{(32-csrmv_pkg::DIM_W){1'b0}}, num_rows} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= csrmv_pkg::DIM_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      num_rows <= pwdata[csrmv_pkg::DIM_W-1:0];
    end
  end

  // Zero acts as one and anything above the store depth as the full depth.
  always_comb begin
    if (num_rows == '0) begin
      dim = csrmv_pkg::DIM_W'(1);
    end else if (num_rows > csrmv_pkg::DIM_W'(csrmv_pkg::VEC_DEPTH)) begin
      dim = csrmv_pkg::DIM_W'(csrmv_pkg::VEC_DEPTH);
    end else begin
      dim = num_rows;
    end
  end

  csrmv_front u_front (
    .clk          (clk),
    .rst          (rst),
    .dim          (dim),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .vector_index (vector_index),
    .vector_value (vector_value),
    .matrix_value (matrix_value),
    .column       (column),
    .item_valid   (front_valid),
    .item_ready   (front_ready),
    .item         (front_item)
  );

  csrmv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  csrmv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .dim        (dim),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_result (row_result),
    .row_number (row_number),
    .last_row   (last_row)
  );

endmodule

### hdl/csrmv_front.sv
module csrmv_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [csrmv_pkg::DIM_W-1:0] dim,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  operation,
  input  logic [csrmv_pkg::IDX_W-1:0] vector_index,
  input  logic [csrmv_pkg::VAL_W-1:0] vector_value,
  input  logic [csrmv_pkg::VAL_W-1:0] matrix_value,
  input  logic [csrmv_pkg::IDX_W-1:0] column,
  output logic                        item_valid,
  input  logic                        item_ready,
  output csrmv_pkg::item_t            item
);

  csrmv_pkg::item_t item_next;
  logic             held;

  assign in_ready   = !held || item_ready;
  assign item_valid = held;

  always_comb begin
    item_next.op = operation;
    if (operation == csrmv_pkg::OP_LOAD) begin
      item_next.index = vector_index;
      item_next.value = vector_value;
    end else begin
      item_next.index = column;
      item_next.value = matrix_value;
    end
    item_next.in_range = ({1'b0, item_next.index} < dim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      // Unused operation codes are accepted and dropped here.
      held <= in_valid && (operation != csrmv_pkg::OP_UNUSED);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

### hdl/csrmv_queue.sv
module csrmv_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  csrmv_pkg::item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output csrmv_pkg::item_t pop_item
);

  csrmv_pkg::item_t               entries [csrmv_pkg::QUEUE_DEPTH];
  logic [csrmv_pkg::QPTR_W-1:0]   wptr;
  logic [csrmv_pkg::QPTR_W-1:0]   rptr;
  logic [csrmv_pkg::QCNT_W-1:0]   count;
  logic                           push;
  logic                           pop;

  assign push_ready = (count != csrmv_pkg::QCNT_W'(csrmv_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

endmodule

### hdl/csrmv_back.sv
module csrmv_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [csrmv_pkg::DIM_W-1:0] dim,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  csrmv_pkg::item_t            item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [csrmv_pkg::VAL_W-1:0] row_result,
  output logic [csrmv_pkg::IDX_W-1:0] row_number,
  output logic                        last_row
);

  logic [csrmv_pkg::VAL_W-1:0] vec_mem [csrmv_pkg::VEC_DEPTH];

  logic                               advance;

  // Stage 1: vector store read data and the matrix value.
  logic                               s1_valid;
  logic [1:0]                         s1_op;
  logic                               s1_in_range;
  logic signed [csrmv_pkg::VAL_W-1:0] s1_aval;
  logic signed [csrmv_pkg::VAL_W-1:0] s1_xval;

  // Stage 2: registered product.
  logic                               s2_valid;
  logic [1:0]                         s2_op;
  logic signed [csrmv_pkg::ACC_W-1:0] s2_prod;
  logic signed [csrmv_pkg::ACC_W-1:0] prod_next;

  logic signed [csrmv_pkg::ACC_W-1:0] acc;
  logic signed [csrmv_pkg::ACC_W-1:0] acc_next;
  logic signed [csrmv_pkg::ACC_W-1:0] sum;
  logic signed [csrmv_pkg::ACC_W-1:0] shifted;
  logic [csrmv_pkg::VAL_W-1:0]        result_next;
  logic [csrmv_pkg::IDX_W-1:0]        row_counter;
  logic [csrmv_pkg::DIM_W-1:0]        row_plus_one;
  logic                               row_end;

  // The whole back pipeline holds only while a finished row waits at the output.
  assign advance    = !out_valid || out_ready;
  assign item_ready = advance;
  assign row_end    = s2_valid && (s2_op == csrmv_pkg::OP_ROW_END);

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      if (item.op == csrmv_pkg::OP_LOAD) begin
        if (item.in_range) begin
          vec_mem[item.index] <= item.value;
        end
      end else begin
        s1_xval <= vec_mem[item.index];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op       <= item.op;
      s1_in_range <= item.in_range;
      s1_aval     <= item.value;
      s2_op       <= s1_op;
      s2_prod     <= prod_next;
    end
  end

  always_comb begin
    if (s1_in_range) begin
      prod_next = s1_aval * s1_xval;
    end else begin
      prod_next = '0;
    end
  end

  // Saturating accumulate: overflow only when both operands share a sign.
  always_comb begin
    sum = acc + s2_prod;
    if (!acc[csrmv_pkg::ACC_W-1] && !s2_prod[csrmv_pkg::ACC_W-1]
        && sum[csrmv_pkg::ACC_W-1]) begin
      acc_next = {1'b0, {(csrmv_pkg::ACC_W-1){1'b1}}};
    end else if (acc[csrmv_pkg::ACC_W-1] && s2_prod[csrmv_pkg::ACC_W-1]
                 && !sum[csrmv_pkg::ACC_W-1]) begin
      acc_next = {1'b1, {(csrmv_pkg::ACC_W-1){1'b0}}};
    end else begin
      acc_next = sum;
    end
  end

  // An arithmetic shift is a floor; then clamp to the 32-bit range.
  always_comb begin
    shifted = acc >>> csrmv_pkg::FRAC_W;
    if (!shifted[csrmv_pkg::ACC_W-1]
        && (|shifted[csrmv_pkg::ACC_W-2:csrmv_pkg::VAL_W-1])) begin
      result_next = {1'b0, {(csrmv_pkg::VAL_W-1){1'b1}}};
    end else if (shifted[csrmv_pkg::ACC_W-1]
                 && !(&shifted[csrmv_pkg::ACC_W-2:csrmv_pkg::VAL_W-1])) begin
      result_next = {1'b1, {(csrmv_pkg::VAL_W-1){1'b0}}};
    end else begin
      result_next = shifted[csrmv_pkg::VAL_W-1:0];
    end
  end

  assign row_plus_one = {1'b0, row_counter} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      out_valid   <= 1'b0;
      acc         <= '0;
      row_counter <= '0;
    end else if (advance) begin
      s1_valid  <= item_valid;
      s2_valid  <= s1_valid;
      out_valid <= row_end;
      if (s2_valid && (s2_op == csrmv_pkg::OP_NONZERO)) begin
        acc <= acc_next;
      end else if (row_end) begin
        acc <= '0;
        if (row_plus_one >= dim) begin
          row_counter <= '0;
        end else begin
          row_counter <= row_plus_one[csrmv_pkg::IDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && row_end) begin
      row_result <= result_next;
      row_number <= row_counter;
      last_row   <= ({1'b0, row_counter} == (dim - 1'b1));
    end
  end

endmodule
